// ----- rtl/mbc_pkg.sv -----
package mbc_pkg;

  // field widths of the ports
  localparam int OP_W   = 1;
  localparam int RND_W  = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 6;
  localparam int DIR_W  = 2;
  localparam int RCFG_W = 6;
  localparam int CCFG_W = 7;
  localparam int IDX_W  = 2;
  localparam int DATA_W = 8;

  // grid sizes after clamping are held and compared in nine bits
  localparam int SZW = 9;

  localparam logic [RCFG_W-1:0] ROWS_RESET = RCFG_W'(20);
  localparam logic [CCFG_W-1:0] COLS_RESET = CCFG_W'(40);

  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [IDX_W-1:0] REG_ROWS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COLS = IDX_W'(1);

  typedef enum logic [DIR_W-1:0] {
    DIR_TOP    = 2'd0,
    DIR_RIGHT  = 2'd1,
    DIR_BOTTOM = 2'd2,
    DIR_LEFT   = 2'd3
  } dir_t;

  function automatic logic [SZW-1:0] clamp_size(logic [SZW-1:0] v, logic [SZW-1:0] maxv);
    logic [SZW-1:0] r;
    if (v == '0) r = SZW'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

  // base-4 digit sum, since 4 is 1 mod 3
  function automatic logic [1:0] mod3_u8(logic [RND_W-1:0] v);
    logic [3:0] s1;
    logic [2:0] s2;
    s1 = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
    if (s2 >= 3'd3) s2 = s2 - 3'd3;
    if (s2 >= 3'd3) s2 = s2 - 3'd3;
    return s2[1:0];
  endfunction

endpackage

// ----- rtl/maze_backtracker_carver_unit.sv -----
// Randomized depth-first maze carver over a rows_in_use by cols_in_use grid.
// Input channel (in_valid / in_stall): operation and random_value. A restart
// clears the visited map and stacks cell (0,0); a step pops the top cell,
// picks one of its unvisited neighbors (random_value mod candidate count),
// marks and stacks it, and reports the carved passage.
// Output channel (out_valid / out_stall): exactly one result per input item.
// Config channel (cfg_valid / cfg_ready): index 0 rows, 1 cols; always ready;
// write only while the block is idle.
// A step's result is formed in this order: stack read on the transfer edge, then
// reads of the rows above and below, read of the cell's own row, then
// evaluation and write-back. The three visited-row reads go through a
// two-port row memory. Restart and a step on an empty stack go straight
// from the transfer to the output state.
// The input is stalled while an item is worked on, so a new item is taken
// only once the block is through with the last one.
// The result sits in an output register; the next item is accepted while it
// waits, and a finished result that meets a stalled output waits in a holding
// register, keeping the input stalled until it moves out.
// Reset: sizes go to 20 by 40, the stack empties and per-row valid bits clear
// the visited map at once; no clearing pass is needed.
module maze_backtracker_carver_unit #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mbc_pkg::OP_W-1:0]     operation,
  input  logic [mbc_pkg::RND_W-1:0]    random_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         carved,
  output logic [mbc_pkg::ROW_W-1:0]    from_row,
  output logic [mbc_pkg::COL_W-1:0]    from_col,
  output logic [mbc_pkg::DIR_W-1:0]    direction,
  output logic                         done_res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mbc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [mbc_pkg::DATA_W-1:0]   cfg_data
);
  import mbc_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNTW  = $clog2(CELLS + 1);

  typedef enum logic [2:0] {S_IDLE, S_CELL, S_MID, S_EVAL, S_OUT} state_t;

  state_t              state;
  logic [RCFG_W-1:0]   rows_in_use;
  logic [CCFG_W-1:0]   cols_in_use;
  logic [CNTW-1:0]     count;
  logic [MAX_ROWS-1:0] row_valid;
  logic [RND_W-1:0]    rnd_q;
  logic [RW-1:0]       cell_r;
  logic [CW-1:0]       cell_c;
  logic [MAX_COLS-1:0] top_word;
  logic                res_carved;
  logic [ROW_W-1:0]    res_row;
  logic [COL_W-1:0]    res_col;
  logic [DIR_W-1:0]    res_dir;
  logic                res_done;

  // memories
  logic [MAX_COLS-1:0] vis_mem [MAX_ROWS];
  logic [RW+CW-1:0]    stk_mem [CELLS];
  logic [MAX_COLS-1:0] vis_a;
  logic [MAX_COLS-1:0] vis_b;
  logic [RW+CW-1:0]    stk_rd;

  logic                vis_we;
  logic [RW-1:0]       vis_wa;
  logic [MAX_COLS-1:0] vis_wd;
  logic                vis_ra_en;
  logic [RW-1:0]       vis_ra;
  logic                vis_rb_en;
  logic [RW-1:0]       vis_rb;
  logic                stk_we;
  logic [AW-1:0]       stk_wa;
  logic [RW+CW-1:0]    stk_wd;
  logic                stk_re;
  logic [AW-1:0]       stk_ra;

  logic                accept;
  logic                out_free;
  logic                out_load;
  logic [SZW-1:0]      rows_eff;
  logic [SZW-1:0]      cols_eff;
  logic [RW-1:0]       rd_r;
  logic [CW-1:0]       rd_c;
  logic [RW-1:0]       src_r;
  logic                ok_top;
  logic                ok_rt;
  logic                ok_bot;
  logic                ok_lf;
  logic [RW-1:0]       r_up;
  logic [RW-1:0]       r_dn;
  logic [CW-1:0]       c_rt;
  logic [CW-1:0]       c_lf;
  logic [MAX_COLS-1:0] top_eff;
  logic [MAX_COLS-1:0] mid_eff;
  logic [MAX_COLS-1:0] bot_eff;
  logic [3:0]          cand;
  logic [2:0]          n_cand;
  logic [1:0]          sel;
  logic [2:0]          seen;
  dir_t                dir_pick;
  logic [RW-1:0]       nr;
  logic [CW-1:0]       nc;
  logic [MAX_COLS-1:0] nword;
  logic                ev_carve;
  logic                ev_full;
  logic [CNTW-1:0]     count_next;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = ((state == S_EVAL) || (state == S_OUT)) && out_free;
  assign cfg_ready = 1'b1;

  assign rows_eff = clamp_size(SZW'(rows_in_use), SZW'(MAX_ROWS));
  assign cols_eff = clamp_size(SZW'(cols_in_use), SZW'(MAX_COLS));

  assign rd_r  = stk_rd[RW+CW-1:CW];
  assign rd_c  = stk_rd[CW-1:0];
  // neighbor rows come from the stack word while it arrives, then from the cell register
  assign src_r = (state == S_CELL) ? rd_r : cell_r;

  always_comb begin
    ok_top = (src_r != '0);
    ok_bot = ((SZW'(src_r) + SZW'(1)) < rows_eff);
    ok_rt  = ((SZW'(cell_c) + SZW'(1)) < cols_eff);
    ok_lf  = (cell_c != '0);
    // clamped so that no address ever leaves the grid
    r_up   = ok_top ? (src_r - RW'(1)) : src_r;
    r_dn   = ok_bot ? (src_r + RW'(1)) : src_r;
    c_rt   = ok_rt ? (cell_c + CW'(1)) : cell_c;
    c_lf   = ok_lf ? (cell_c - CW'(1)) : cell_c;
  end

  // a row never written since restart reads as all clear
  assign top_eff = row_valid[r_up] ? top_word : '0;
  assign mid_eff = row_valid[cell_r] ? vis_a : '0;
  assign bot_eff = row_valid[r_dn] ? vis_b : '0;

  always_comb begin
    cand[0] = ok_top && !top_eff[cell_c];
    cand[1] = ok_rt && !mid_eff[c_rt];
    cand[2] = ok_bot && !bot_eff[cell_c];
    cand[3] = ok_lf && !mid_eff[c_lf];
    n_cand  = 3'($countones(cand));
    unique case (n_cand)
      3'd2:    sel = {1'b0, rnd_q[0]};
      3'd3:    sel = mod3_u8(rnd_q);
      3'd4:    sel = rnd_q[1:0];
      default: sel = 2'd0;
    endcase
    seen     = '0;
    dir_pick = DIR_TOP;
    for (int i = 0; i < 4; i++) begin
      if (cand[i]) begin
        if (seen == 3'(sel)) dir_pick = dir_t'(2'(i));
        seen = seen + 3'd1;
      end
    end
    unique case (dir_pick)
      DIR_TOP: begin
        nr = r_up;   nc = cell_c; nword = top_eff;
      end
      DIR_RIGHT: begin
        nr = cell_r; nc = c_rt;   nword = mid_eff;
      end
      DIR_BOTTOM: begin
        nr = r_dn;   nc = cell_c; nword = bot_eff;
      end
      DIR_LEFT: begin
        nr = cell_r; nc = c_lf;   nword = mid_eff;
      end
    endcase
    ev_carve = |cand;
    ev_full  = (count >= CNTW'(CELLS));
    // the popped cell goes back to the same slot, so only the neighbor is written
    if (ev_carve) count_next = ev_full ? count : count + CNTW'(1);
    else count_next = count - CNTW'(1);
  end

  // memory port control
  always_comb begin
    vis_we    = 1'b0;
    vis_wa    = '0;
    vis_wd    = MAX_COLS'(1);
    vis_ra_en = 1'b0;
    vis_ra    = r_up;
    vis_rb_en = 1'b0;
    vis_rb    = r_dn;
    stk_we    = 1'b0;
    stk_wa    = '0;
    stk_wd    = '0;
    stk_re    = 1'b0;
    stk_ra    = AW'(count - CNTW'(1));
    unique case (state)
      S_IDLE: begin
        if (accept && operation == OP_RESTART) begin
          vis_we = 1'b1;
          stk_we = 1'b1;
        end else if (accept && count != '0) begin
          stk_re = 1'b1;
        end
      end
      S_CELL: begin
        vis_ra_en = 1'b1;
        vis_rb_en = 1'b1;
      end
      S_MID: begin
        vis_ra_en = 1'b1;
        vis_ra    = cell_r;
      end
      S_EVAL: begin
        if (ev_carve) begin
          vis_we = 1'b1;
          vis_wa = nr;
          vis_wd = nword | (MAX_COLS'(1) << nc);
          stk_we = !ev_full;
          stk_wa = AW'(count);
          stk_wd = {nr, nc};
        end
      end
      S_OUT: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (vis_ra_en) vis_a <= vis_mem[vis_ra];
    if (vis_rb_en) vis_b <= vis_mem[vis_rb];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
      count       <= '0;
      row_valid   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROWS) rows_in_use <= cfg_data[RCFG_W-1:0];
        else if (cfg_index == REG_COLS) cols_in_use <= cfg_data[CCFG_W-1:0];
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_carved <= 1'b0;
            res_row    <= '0;
            res_col    <= '0;
            res_dir    <= DIR_TOP;
            rnd_q      <= random_value;
            if (operation == OP_RESTART) begin
              count     <= CNTW'(1);
              row_valid <= MAX_ROWS'(1);
              res_done  <= 1'b0;
              state     <= S_OUT;
            end else if (count == '0) begin
              res_done <= 1'b1;
              state    <= S_OUT;
            end else begin
              state <= S_CELL;
            end
          end
        end
        S_CELL: begin
          cell_r <= rd_r;
          cell_c <= rd_c;
          state  <= S_MID;
        end
        S_MID: begin
          top_word <= vis_a;
          state    <= S_EVAL;
        end
        S_EVAL: begin
          count <= count_next;
          if (ev_carve) row_valid[nr] <= 1'b1;
          res_carved <= ev_carve;
          res_row    <= ev_carve ? ROW_W'(cell_r) : '0;
          res_col    <= ev_carve ? COL_W'(cell_c) : '0;
          res_dir    <= ev_carve ? dir_pick : DIR_TOP;
          res_done   <= (count_next == '0);
          if (out_free) begin
            carved    <= ev_carve;
            from_row  <= ev_carve ? ROW_W'(cell_r) : '0;
            from_col  <= ev_carve ? COL_W'(cell_c) : '0;
            direction <= ev_carve ? dir_pick : DIR_TOP;
            done_res  <= (count_next == '0);
            state     <= S_IDLE;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            carved    <= res_carved;
            from_row  <= res_row;
            from_col  <= res_col;
            direction <= res_dir;
            done_res  <= res_done;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_carve_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && carved |-> !done_res)
    else $error("carved result reports an empty stack");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(CELLS))
    else $error("stack count beyond capacity");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && operation == OP_RESTART |=> count == CNTW'(1) && row_valid[0])
    else $error("restart did not stack the origin cell");

  a_push: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL && ev_carve && !ev_full |=> count == $past(count) + CNTW'(1))
    else $error("carve did not grow the stack");

  a_pop: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL && !ev_carve |=> count == $past(count) - CNTW'(1))
    else $error("dead end did not shrink the stack");
`endif

endmodule

// ----- tb/tb.sv -----
module tb;
  import mbc_pkg::*;

  localparam int GRID_ROWS   = 32;
  localparam int GRID_COLS   = 64;
  localparam int GRID_CELLS  = GRID_ROWS * GRID_COLS;
  localparam int RAND_ITEMS  = 1300;
  localparam int MAX_WALK    = 300;
  localparam int SETTLE_CYC  = 8;
  localparam int CYCLE_LIMIT = 400000;

  // indexes with no register behind them
  localparam logic [IDX_W-1:0] REG_SPARE_A = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SPARE_B = IDX_W'(3);

  typedef struct {
    logic             op;
    logic [RND_W-1:0] rv;
  } walk_item_t;

  typedef struct {
    logic             carved;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    dir_t             dir;
    logic             done;
  } carve_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    operation = OP_STEP;
  logic [RND_W-1:0]   random_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               carved;
  logic [ROW_W-1:0]   from_row;
  logic [COL_W-1:0]   from_col;
  logic [DIR_W-1:0]   direction;
  logic               done_res;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]  cfg_data = '0;

  maze_backtracker_carver_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .random_value (random_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .carved       (carved),
    .from_row     (from_row),
    .from_col     (from_col),
    .direction    (direction),
    .done_res     (done_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predictor state
  bit          visited [GRID_CELLS];
  int unsigned walk_stack [GRID_CELLS];
  int unsigned walk_depth = 0;
  int unsigned rows_cfg = ROWS_RESET;
  int unsigned cols_cfg = COLS_RESET;

  walk_item_t  walk_q [$];
  carve_t      carve_q [$];
  int          error_cnt = 0;
  int unsigned cycle_cnt = 0;

  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic carve_t predict_carve(logic op, logic [RND_W-1:0] rv);
    carve_t      res;
    dir_t        cand [4];
    int unsigned nrows, ncols, cur_cell, r, c, n, nxt;
    res.carved = 1'b0;
    res.row    = '0;
    res.col    = '0;
    res.dir    = DIR_TOP;
    if (op == OP_RESTART) begin
      foreach (visited[i]) visited[i] = 1'b0;
      visited[0]    = 1'b1;
      walk_stack[0] = 0;
      walk_depth    = 1;
    end else if (walk_depth > 0) begin
      nrows = clip(rows_cfg, GRID_ROWS);
      ncols = clip(cols_cfg, GRID_COLS);
      walk_depth--;
      cur_cell = walk_stack[walk_depth];
      r    = cur_cell / GRID_COLS;
      c    = cur_cell % GRID_COLS;
      n    = 0;
      // neighbor scan order is top, right, bottom, left
      if (r > 0 && !visited[cur_cell - GRID_COLS]) begin cand[n] = DIR_TOP; n++; end
      if (c + 1 < ncols && !visited[cur_cell + 1]) begin cand[n] = DIR_RIGHT; n++; end
      if (r + 1 < nrows && !visited[cur_cell + GRID_COLS]) begin
        cand[n] = DIR_BOTTOM; n++;
      end
      if (c > 0 && !visited[cur_cell - 1]) begin cand[n] = DIR_LEFT; n++; end
      if (n > 0) begin
        res.dir = cand[rv % n];
        case (res.dir)
          DIR_TOP:    nxt = cur_cell - GRID_COLS;
          DIR_RIGHT:  nxt = cur_cell + 1;
          DIR_BOTTOM: nxt = cur_cell + GRID_COLS;
          default:    nxt = cur_cell - 1;
        endcase
        visited[nxt] = 1'b1;
        walk_stack[walk_depth]     = cur_cell;
        walk_stack[walk_depth + 1] = nxt;
        walk_depth += 2;
        res.carved = 1'b1;
        res.row    = ROW_W'(r);
        res.col    = COL_W'(c);
      end
    end
    res.done = (walk_depth == 0);
    return res;
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
      error_cnt++;
    end
  endfunction

  // driver: bursts of random length separated by random gaps
  walk_item_t  drv_item;
  carve_t      drv_pred;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        drv_pred = predict_carve(operation, random_value);
        carve_q = {carve_q, drv_pred};
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (walk_q.size() > 0) begin
          drv_item = walk_q.pop_front();
          in_valid     <= 1'b1;
          operation    <= drv_item.op;
          random_value <= drv_item.rv;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer, stalls on a mode pattern
  carve_t      mon_want;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned run_left = 0;
  bit          run_val = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (carve_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual carved %0d row %0d col %0d",
                   $time, carved, from_row, from_col);
          error_cnt++;
        end else begin
          mon_want = carve_q.pop_front();
          check_field("carved", mon_want.carved, carved);
          check_field("from_row", mon_want.row, from_row);
          check_field("from_col", mon_want.col, from_col);
          check_field("direction", mon_want.dir, direction);
          check_field("done_res", mon_want.done, done_res);
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          // long stall stretches
          if (run_left == 0) begin
            run_val  = !run_val;
            run_left = run_val ? $urandom_range(1, 16) : $urandom_range(1, 6);
          end else begin
            run_left--;
          end
          out_stall <= run_val;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_item(logic op, logic [RND_W-1:0] rv);
    walk_item_t it;
    it.op = op;
    it.rv = rv;
    walk_q = {walk_q, it};
  endtask

  // sender holds off until every result is back, then lets the block settle
  task automatic wait_idle();
    do @(negedge clk); while (walk_q.size() != 0 || in_valid || carve_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ROWS) rows_cfg = val[RCFG_W-1:0];
    else if (idx == REG_COLS) cols_cfg = val[CCFG_W-1:0];
  endtask

  initial begin : stim
    int unsigned rand_total;
    int unsigned phase;
    int unsigned walk_len;
    int unsigned nr, nc;
    logic [DATA_W-1:0] rdat, cdat;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // default 20x40 grid: steps on an empty stack, restart, a short walk
    queue_item(OP_STEP, 8'h00);
    queue_item(OP_STEP, 8'hFF);
    queue_item(OP_RESTART, 8'hA5);
    queue_item(OP_STEP, 8'h00);
    queue_item(OP_STEP, 8'hFF);
    queue_item(OP_STEP, 8'h55);
    queue_item(OP_STEP, 8'hAA);
    queue_item(OP_STEP, 8'h01);
    queue_item(OP_STEP, 8'h02);
    queue_item(OP_STEP, 8'h03);
    queue_item(OP_RESTART, 8'h5A);
    queue_item(OP_STEP, 8'h80);
    wait_idle();

    // single cell grid: the only cell pops with no neighbor and the walk ends
    write_reg(REG_ROWS, 8'd1);
    write_reg(REG_COLS, 8'd1);
    queue_item(OP_RESTART, 8'h00);
    queue_item(OP_STEP, 8'h7F);
    queue_item(OP_STEP, 8'hFE);
    wait_idle();

    // zero sizes clamp to one, spare indexes are ignored
    write_reg(REG_ROWS, 8'd0);
    write_reg(REG_COLS, 8'd0);
    write_reg(REG_SPARE_A, 8'hFF);
    write_reg(REG_SPARE_B, 8'h00);
    queue_item(OP_RESTART, 8'hFF);
    queue_item(OP_STEP, 8'h10);
    queue_item(OP_STEP, 8'h20);
    wait_idle();

    write_reg(REG_ROWS, 8'd1);
    write_reg(REG_COLS, 8'd3);
    queue_item(OP_RESTART, 8'h01);
    queue_item(OP_STEP, 8'hFF);
    queue_item(OP_STEP, 8'h04);
    queue_item(OP_STEP, 8'h40);
    queue_item(OP_STEP, 8'h08);
    wait_idle();

    rand_total = 0;
    phase = 0;
    while (rand_total < RAND_ITEMS) begin
      case (phase)
        0: begin rdat = 8'd32; cdat = 8'd2; end
        1: begin rdat = 8'd2; cdat = 8'd64; end
        2: begin rdat = 8'hFF; cdat = 8'hFF; end
        3: begin rdat = 8'h40; cdat = 8'h80; end
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            rdat = DATA_W'($urandom_range(0, 255));
            cdat = DATA_W'($urandom_range(0, 255));
          end else begin
            rdat = DATA_W'($urandom_range(1, 6) | ($urandom_range(0, 3) << RCFG_W));
            cdat = DATA_W'($urandom_range(1, 8) | ($urandom_range(0, 1) << CCFG_W));
          end
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_ROWS, rdat);
        write_reg(REG_COLS, cdat);
      end else begin
        write_reg(REG_COLS, cdat);
        write_reg(REG_ROWS, rdat);
      end
      if ($urandom_range(0, 5) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                  DATA_W'($urandom_range(0, 255)));

      nr = clip(rdat[RCFG_W-1:0], GRID_ROWS);
      nc = clip(cdat[CCFG_W-1:0], GRID_COLS);
      walk_len = 2 * nr * nc + $urandom_range(0, 3);
      if (walk_len > MAX_WALK) walk_len = $urandom_range(150, MAX_WALK);
      // cut some walks short so the next size change lands mid-walk
      if (phase >= 4 && $urandom_range(0, 2) == 0) walk_len = walk_len / 2 + 1;

      // most phases start a fresh walk, the rest continue the old one
      if (phase < 4 || $urandom_range(0, 3) != 0)
        queue_item(OP_RESTART, RND_W'($urandom_range(0, 255)));
      repeat (walk_len) begin
        if ($urandom_range(0, 49) == 0) queue_item(OP_RESTART, RND_W'($urandom_range(0, 255)));
        else queue_item(OP_STEP, RND_W'($urandom_range(0, 255)));
      end
      rand_total += walk_len + 1;
      wait_idle();
      phase++;
    end

    if (error_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- maze_backtracker_carver_unit.f -----
rtl/mbc_pkg.sv
rtl/maze_backtracker_carver_unit.sv
tb/tb.sv
